// ===== rtl/stok_pkg.sv =====
// Package for the source tokenizer: item types, token kinds, error codes and helpers.
package stok_pkg;

  localparam int OffsetBitsDefault = 32;
  localparam int MaxNestingDefault = 255;
  localparam int ResMax = 4;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic [2:0]  error_code;
    logic        run_end;
  } out_item_t;

  // Up to four result items caused by one input item.
  typedef struct packed {
    logic [2:0]            n;
    out_item_t [ResMax-1:0] ent;
  } res_list_t;

  typedef enum logic [4:0] {
    M_START, M_MINUS, M_SLASH, M_LINE, M_BLK, M_BLK_SLASH, M_BLK_STAR,
    M_IDENT, M_ZERO, M_PREFIX, M_DEC_D, M_DEC_U, M_BASE_D, M_BASE_U,
    M_ASM_WS, M_ASM_BODY, M_ASM_SLASH, M_ASM_LINE, M_DISCARD
  } lex_mode_t;

  typedef enum logic [1:0] {RX_DEC, RX_OCT, RX_HEX, RX_BIN} radix_t;

  localparam logic [4:0] K_ARROW = 5'd1;
  localparam logic [4:0] K_MINUS = 5'd2;
  localparam logic [4:0] K_SLASH = 5'd4;
  localparam logic [4:0] K_KW0   = 5'd14;
  localparam logic [4:0] K_ASM   = 5'd17;
  localparam logic [4:0] K_IDENT = 5'd18;
  localparam logic [4:0] K_INT   = 5'd19;
  localparam logic [4:0] K_EOF   = 5'd20;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_UNCLOSED = 3'd1;
  localparam logic [2:0] E_UNEXPECT = 3'd2;
  localparam logic [2:0] E_EOF_BSM  = 3'd3;
  localparam logic [2:0] E_NO_BRACE = 3'd4;
  localparam logic [2:0] E_ASM_OPEN = 3'd5;
  localparam logic [2:0] E_DEEP     = 3'd6;

  // Keyword texts, first character in the top byte; the first is the register-dump keyword.
  localparam logic [8*14-1:0] KwDump = 112'h64756D705F726567697374657273;
  localparam logic [8*8-1:0]  KwFunc = "function";
  localparam logic [8*3-1:0]  KwLet  = "let";
  localparam logic [8*3-1:0]  KwBsm  = "bsm";

  function automatic logic [4:0] kw_len(input logic [1:0] k);
    case (k)
      2'd0:    return 5'd14;
      2'd1:    return 5'd8;
      default: return 5'd3;
    endcase
  endfunction

  // Character of keyword k at position idx; idx is below its length.
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] idx);
    case (k)
      2'd0:    return KwDump[8*(13-idx) +: 8];
      2'd1:    return KwFunc[8*(7-idx) +: 8];
      2'd2:    return KwLet[8*(2-idx) +: 8];
      default: return KwBsm[8*(2-idx) +: 8];
    endcase
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic radix_digit(input radix_t rx, input logic [7:0] c);
    case (rx)
      RX_OCT:  return c >= "0" && c <= "7";
      RX_BIN:  return c == "0" || c == "1";
      RX_HEX:  return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
      default: return is_digit(c);
    endcase
  endfunction

  // Single-character operators: valid bit and kind.
  function automatic logic [5:0] op_kind(input logic [7:0] c);
    case (c)
      "+":     return {1'b1, 5'd0};
      "*":     return {1'b1, 5'd3};
      "%":     return {1'b1, 5'd5};
      "(":     return {1'b1, 5'd6};
      ")":     return {1'b1, 5'd7};
      ";":     return {1'b1, 5'd8};
      "{":     return {1'b1, 5'd9};
      "}":     return {1'b1, 5'd10};
      ":":     return {1'b1, 5'd11};
      ",":     return {1'b1, 5'd12};
      "=":     return {1'b1, 5'd13};
      default: return 6'd0;
    endcase
  endfunction

  // Adds one character to an identifier: returns updated {candidates, length}.
  function automatic logic [8:0] ident_add(input logic [3:0] cand, input logic [4:0] il,
                                           input logic [7:0] c);
    logic [3:0] cn;
    cn = cand;
    for (int k = 0; k < 4; k++) begin
      if (cand[k]) begin
        if (il >= kw_len(2'(k)) || kw_char(2'(k), il[3:0]) != c) cn[k] = 1'b0;
      end
    end
    return {cn, (il < 5'd31) ? il + 5'd1 : il};
  endfunction

  function automatic res_list_t push(input res_list_t l, input logic [4:0] kind,
                                     input logic [31:0] s, input logic [31:0] e,
                                     input logic [2:0] err);
    res_list_t r;
    r = l;
    if (l.n < 3'(ResMax)) begin
      r.ent[l.n[1:0]] = '{token_kind: kind, start_offset: s, end_offset: e,
                          error_code: err, run_end: 1'b0};
      r.n = l.n + 3'd1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/source_tokenizer.sv =====
// Streaming source tokenizer: lexer state, token decode and result buffer.
//
// Usage: source bytes enter on the in_ channel (valid/stall), one byte per item,
// with final_byte set on the last byte of a source. Tokens leave on the out_
// channel, each with kind, start and end offsets, an error code and run_end,
// which marks the last result caused by one input byte.
// Latency: the first result of a byte appears on out_ the cycle after it is accepted.
// Throughput: one byte per cycle while each byte causes at most one token and
// out_stall is low; a byte that causes more than one token stalls the input
// until its tokens drain, since the four-entry result buffer drains one token
// per cycle while out_stall is low, taking the next byte as its last entry leaves.
// A byte that ends a token is lexed in the same cycle, so the whole lexer step
// is one registered pass over the mode, start offset and keyword candidates.
// Reset: the lexer returns to the start-of-token state at offset zero and the
// result buffer empties. A final byte also resets the lexer for the next source.
// Stall: while out_stall is high the current token holds and in_stall stays
// high as long as any token is buffered.
module source_tokenizer
  import stok_pkg::*;
#(
  parameter int OFFSET_BITS = OffsetBitsDefault,
  parameter int MAX_NESTING = MaxNestingDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int DW = $clog2(MAX_NESTING + 1);
  localparam logic [OFFSET_BITS-1:0] OffMax = '1;

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (v == OffMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [31:0] clip(input logic [OFFSET_BITS-1:0] v);
    if (OFFSET_BITS > 32 && (v >> 32) != '0) return 32'hFFFF_FFFF;
    return 32'(v);
  endfunction

  // Lexer state.
  lex_mode_t              mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] ts_r, ts_nxt;
  logic [DW-1:0]          dp_r, dp_nxt;
  logic [3:0]             cand_r, cand_nxt;
  logic [4:0]             il_r, il_nxt;
  radix_t                 rx_r, rx_nxt;

  // Result buffer.
  out_item_t [ResMax-1:0] buf_r;
  logic [2:0]             cnt_r;
  logic [1:0]             rd_r;

  res_list_t              res;
  logic                   in_acc, out_acc;

  assign out_valid = cnt_r != 3'd0;
  assign out_data  = buf_r[rd_r];
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = !(cnt_r == 3'd0 || (cnt_r == 3'd1 && !out_stall));
  assign in_acc    = in_valid && !in_stall;

  // One lexer step for the byte on the input.
  always_comb begin
    logic [7:0]             c;
    logic                   go;
    logic [5:0]             op;
    logic [8:0]             ia;
    logic [4:0]             kind;
    logic [7:0]             pl;
    logic [OFFSET_BITS-1:0] off, len;
    lex_mode_t              m;
    logic [OFFSET_BITS-1:0] ts;
    logic [DW-1:0]          dp;
    logic [3:0]             cd;
    logic [4:0]             il;
    radix_t                 rx;
    res_list_t              r;

    c   = in_data.source_byte;
    off = off_r;
    m   = mode_r;
    ts  = ts_r;
    dp  = dp_r;
    cd  = cand_r;
    il  = il_r;
    rx  = rx_r;
    r   = '0;
    go  = 1'b1;
    op  = '0;
    ia  = '0;
    kind = K_IDENT;
    pl  = '0;
    for (int it = 0; it < 3; it++) begin
      if (go) begin
        go = 1'b0;
        unique case (m)
          M_START: begin
            ts = off;
            op = op_kind(c);
            if (c == "-") m = M_MINUS;
            else if (c == "/") m = M_SLASH;
            else if (op[5]) r = push(r, op[4:0], clip(off), clip(sat_inc(off)), E_NONE);
            else if (is_space(c)) m = M_START;
            else if (is_alpha(c)) begin
              ia = ident_add(4'hF, 5'd0, c);
              cd = ia[8:5];
              il = ia[4:0];
              m  = M_IDENT;
            end else if (c == "0") m = M_ZERO;
            else if (is_digit(c)) m = M_DEC_D;
            else begin
              r = push(r, K_EOF, clip(off), clip(sat_inc(off)), E_UNEXPECT);
              m = M_DISCARD;
            end
          end
          M_MINUS: begin
            if (c == ">") r = push(r, K_ARROW, clip(ts), clip(sat_inc(off)), E_NONE);
            else begin
              r  = push(r, K_MINUS, clip(ts), clip(sat_inc(ts)), E_NONE);
              go = 1'b1;
            end
            m = M_START;
          end
          M_SLASH: begin
            if (c == "/") m = M_LINE;
            else if (c == "*") begin
              dp = DW'(1);
              m  = M_BLK;
            end else begin
              r  = push(r, K_SLASH, clip(ts), clip(sat_inc(ts)), E_NONE);
              m  = M_START;
              go = 1'b1;
            end
          end
          M_LINE: if (c == 8'h0A) m = M_START;
          M_BLK: begin
            if (c == "/") m = M_BLK_SLASH;
            else if (c == "*") m = M_BLK_STAR;
          end
          M_BLK_SLASH: begin
            if (c == "*") begin
              if (dp >= DW'(MAX_NESTING)) begin
                r = push(r, K_EOF, clip(ts), clip(sat_inc(off)), E_DEEP);
                m = M_DISCARD;
              end else begin
                dp = dp + 1'b1;
                m  = M_BLK;
              end
            end else begin
              m  = M_BLK;
              go = 1'b1;
            end
          end
          M_BLK_STAR: begin
            if (c == "/") begin
              if (dp != '0) dp = dp - 1'b1;
              m = (dp == '0) ? M_START : M_BLK;
            end else begin
              m  = M_BLK;
              go = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
              ia = ident_add(cd, il, c);
              cd = ia[8:5];
              il = ia[4:0];
            end else begin
              if (cd[3] && il == 5'd3) m = M_ASM_WS;
              else begin
                kind = K_IDENT;
                for (int k = 0; k < 3; k++)
                  if (cd[k] && il == kw_len(2'(k))) kind = K_KW0 + 5'(k);
                r = push(r, kind, clip(ts), clip(off), E_NONE);
                m = M_START;
              end
              go = 1'b1;
            end
          end
          M_ZERO: begin
            if (c == "o" || c == "x" || c == "b") begin
              rx = (c == "o") ? RX_OCT : ((c == "x") ? RX_HEX : RX_BIN);
              m  = M_PREFIX;
            end else begin
              m  = M_DEC_D;
              go = 1'b1;
            end
          end
          M_DEC_D: begin
            if (is_digit(c)) m = M_DEC_D;
            else if (c == "_") m = M_DEC_U;
            else begin
              r  = push(r, K_INT, clip(ts), clip(off), E_NONE);
              m  = M_START;
              go = 1'b1;
            end
          end
          M_DEC_U: begin
            if (is_digit(c)) m = M_DEC_D;
            else begin
              r  = push(r, K_INT, clip(ts), clip(off), E_NONE);
              m  = M_START;
              go = 1'b1;
            end
          end
          M_PREFIX: begin
            if (radix_digit(rx, c)) m = M_BASE_D;
            else begin
              // The prefix letter falls back to the start of an identifier.
              r  = push(r, K_INT, clip(ts), clip(sat_inc(ts)), E_NONE);
              pl = (rx == RX_OCT) ? "o" : ((rx == RX_HEX) ? "x" : "b");
              ts = sat_inc(ts);
              ia = ident_add(4'hF, 5'd0, pl);
              cd = ia[8:5];
              il = ia[4:0];
              m  = M_IDENT;
              go = 1'b1;
            end
          end
          M_BASE_D: begin
            if (radix_digit(rx, c)) m = M_BASE_D;
            else if (c == "_") m = M_BASE_U;
            else begin
              r  = push(r, K_INT, clip(ts), clip(off), E_NONE);
              m  = M_START;
              go = 1'b1;
            end
          end
          M_BASE_U: begin
            if (radix_digit(rx, c)) m = M_BASE_D;
            else begin
              r  = push(r, K_INT, clip(ts), clip(off), E_NONE);
              m  = M_START;
              go = 1'b1;
            end
          end
          M_ASM_WS: begin
            if (c == "{") m = M_ASM_BODY;
            else if (!is_space(c)) begin
              r = push(r, K_EOF, clip(off), clip(sat_inc(off)), E_NO_BRACE);
              m = M_DISCARD;
            end
          end
          M_ASM_BODY: begin
            if (c == "}") begin
              r = push(r, K_ASM, clip(ts), clip(sat_inc(off)), E_NONE);
              m = M_START;
            end else if (c == "/") m = M_ASM_SLASH;
          end
          M_ASM_SLASH: begin
            if (c == "/") m = M_ASM_LINE;
            else begin
              m  = M_ASM_BODY;
              go = 1'b1;
            end
          end
          M_ASM_LINE: if (c == 8'h0A) m = M_ASM_BODY;
          default: m = m;
        endcase
      end
    end

    // End of source: close the open token or flag an open construct, then add the end-of-file item unless discarding.
    len = sat_inc(off);
    if (in_data.final_byte) begin
      if (m == M_IDENT) begin
        if (cd[3] && il == 5'd3) m = M_ASM_WS;
        else begin
          kind = K_IDENT;
          for (int k = 0; k < 3; k++)
            if (cd[k] && il == kw_len(2'(k))) kind = K_KW0 + 5'(k);
          r = push(r, kind, clip(ts), clip(len), E_NONE);
          m = M_START;
        end
      end
      case (m)
        M_MINUS: r = push(r, K_MINUS, clip(ts), clip(sat_inc(ts)), E_NONE);
        M_SLASH: r = push(r, K_SLASH, clip(ts), clip(sat_inc(ts)), E_NONE);
        M_ZERO, M_DEC_D, M_DEC_U, M_BASE_D, M_BASE_U:
          r = push(r, K_INT, clip(ts), clip(len), E_NONE);
        M_PREFIX: begin
          r = push(r, K_INT, clip(ts), clip(sat_inc(ts)), E_NONE);
          r = push(r, K_IDENT, clip(sat_inc(ts)), clip(len), E_NONE);
        end
        M_BLK, M_BLK_SLASH, M_BLK_STAR: begin
          r = push(r, K_EOF, clip(ts), clip(len), E_UNCLOSED);
          m = M_DISCARD;
        end
        M_ASM_WS: begin
          r = push(r, K_EOF, clip(ts), clip(len), E_EOF_BSM);
          m = M_DISCARD;
        end
        M_ASM_BODY, M_ASM_SLASH, M_ASM_LINE: begin
          r = push(r, K_EOF, clip(ts), clip(len), E_ASM_OPEN);
          m = M_DISCARD;
        end
        default: m = m;
      endcase
      if (m != M_DISCARD) r = push(r, K_EOF, clip(len), clip(sat_inc(len)), E_NONE);
    end
    if (r.n != 3'd0) r.ent[2'(r.n - 3'd1)].run_end = 1'b1;

    res = r;
    if (in_data.final_byte) begin
      mode_nxt = M_START;
      off_nxt  = '0;
      ts_nxt   = '0;
      dp_nxt   = '0;
      cand_nxt = 4'hF;
      il_nxt   = 5'd0;
      rx_nxt   = RX_DEC;
    end else begin
      mode_nxt = m;
      off_nxt  = len;
      ts_nxt   = ts;
      dp_nxt   = dp;
      cand_nxt = cd;
      il_nxt   = il;
      rx_nxt   = rx;
    end
  end

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_START;
      off_r  <= '0;
      ts_r   <= '0;
      dp_r   <= '0;
      cand_r <= 4'hF;
      il_r   <= 5'd0;
      rx_r   <= RX_DEC;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
      off_r  <= off_nxt;
      ts_r   <= ts_nxt;
      dp_r   <= dp_nxt;
      cand_r <= cand_nxt;
      il_r   <= il_nxt;
      rx_r   <= rx_nxt;
    end
  end

  // Result buffer control: load on an accepted item, drain one token a cycle while out_stall is low.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      rd_r  <= 2'd0;
    end else if (in_acc) begin
      cnt_r <= res.n;
      rd_r  <= 2'd0;
    end else if (out_acc) begin
      cnt_r <= cnt_r - 3'd1;
      rd_r  <= rd_r + 2'd1;
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk) begin
    if (in_acc) buf_r <= res.ent;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(ResMax))
    else $error("result count exceeds buffer depth");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > 3'd1) |-> in_stall)
    else $error("input taken while buffer still holds several tokens");

  a_run_end_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_data.run_end && !in_acc) |=> (cnt_r == 3'd0))
    else $error("tokens left after the last one of a byte");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cnt_r == 3'd1) |-> out_data.run_end)
    else $error("last buffered token lacks run_end");

endmodule

// ===== dv/source_tokenizer_checker.sv =====
// Token checker for the source tokenizer: lexer model and result comparison.
`timescale 1ns / 1ps

module source_tokenizer_checker
  import stok_pkg::*;
#(
  parameter int MAX_NESTING = MaxNestingDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_tokens
);

  // The register-dump keyword, first character in the top byte.
  localparam logic [111:0] RegDumpWord = 112'h64756D705F726567697374657273;

  // Lexer state of the model.
  lex_mode_t   mode;
  logic [31:0] cur_off;
  logic [31:0] tok_start;
  int unsigned depth;
  logic [3:0]  cand;
  int unsigned id_len;
  int unsigned radix;
  out_item_t   token_queue[$];
  out_item_t   step_tokens[$];

  assign pending_tokens = token_queue.size();

  function automatic logic [31:0] inc_sat(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic bit m_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit m_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit m_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit m_radix_digit(input logic [7:0] c);
    if (radix == 8) return c >= "0" && c <= "7";
    if (radix == 2) return c == "0" || c == "1";
    if (radix == 16) return m_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    return m_digit(c);
  endfunction

  function automatic int m_op(input logic [7:0] c);
    case (c)
      "+": return 0;
      "*": return 3;
      "%": return 5;
      "(": return 6;
      ")": return 7;
      ";": return 8;
      "{": return 9;
      "}": return 10;
      ":": return 11;
      ",": return 12;
      "=": return 13;
      default: return -1;
    endcase
  endfunction

  task automatic add_token(input logic [4:0] kind, input logic [31:0] s,
                           input logic [31:0] e, input logic [2:0] err);
    out_item_t t;
    if (step_tokens.size() >= 4) return;
    t.token_kind = kind;
    t.start_offset = s;
    t.end_offset = e;
    t.error_code = err;
    t.run_end = 1'b0;
    step_tokens = {step_tokens, t};
  endtask

  task automatic raise_error(input logic [2:0] err, input logic [31:0] s, input logic [31:0] e);
    add_token(K_EOF, s, e, err);
    mode = M_DISCARD;
  endtask

  // Narrows the keyword candidates by one identifier character.
  task automatic word_add(input logic [7:0] c);
    string words[4];
    words[0] = $sformatf("%s", RegDumpWord);
    words[1] = "function";
    words[2] = "let";
    words[3] = "bsm";
    for (int k = 0; k < 4; k++) begin
      if (cand[k] && (id_len >= words[k].len() || words[k][id_len] != c)) cand[k] = 1'b0;
    end
    if (id_len < 31) id_len++;
  endtask

  task automatic word_begin(input logic [7:0] c, input logic [31:0] s);
    tok_start = s;
    cand = 4'hF;
    id_len = 0;
    word_add(c);
    mode = M_IDENT;
  endtask

  task automatic word_end(input logic [31:0] e);
    logic [4:0] kind;
    if (cand[3] && id_len == 3) begin
      mode = M_ASM_WS;
      return;
    end
    kind = K_IDENT;
    if (cand[0] && id_len == 14) kind = K_KW0;
    if (cand[1] && id_len == 8) kind = K_KW0 + 5'd1;
    if (cand[2] && id_len == 3) kind = K_KW0 + 5'd2;
    add_token(kind, tok_start, e, E_NONE);
    mode = M_START;
  endtask

  task automatic lexer_reset();
    mode = M_START;
    cur_off = '0;
    tok_start = '0;
    depth = 0;
    cand = 4'hF;
    id_len = 0;
    radix = 10;
  endtask

  // Lexes one byte; a byte that ends a token is lexed again in the new mode.
  task automatic lex_byte(input logic [7:0] c, input logic [31:0] off);
    bit again;
    int k;
    again = 1;
    while (again) begin
      again = 0;
      case (mode)
        M_START: begin
          tok_start = off;
          k = m_op(c);
          if (c == "-") mode = M_MINUS;
          else if (c == "/") mode = M_SLASH;
          else if (k >= 0) add_token(5'(k), off, inc_sat(off), E_NONE);
          else if (m_space(c)) ;
          else if (m_alpha(c)) word_begin(c, off);
          else if (c == "0") mode = M_ZERO;
          else if (m_digit(c)) mode = M_DEC_D;
          else raise_error(E_UNEXPECT, off, inc_sat(off));
        end
        M_MINUS: begin
          if (c == ">") add_token(K_ARROW, tok_start, inc_sat(off), E_NONE);
          else begin
            add_token(K_MINUS, tok_start, inc_sat(tok_start), E_NONE);
            again = 1;
          end
          mode = M_START;
        end
        M_SLASH: begin
          if (c == "/") mode = M_LINE;
          else if (c == "*") begin
            depth = 1;
            mode = M_BLK;
          end else begin
            add_token(K_SLASH, tok_start, inc_sat(tok_start), E_NONE);
            mode = M_START;
            again = 1;
          end
        end
        M_LINE: if (c == 8'h0A) mode = M_START;
        M_BLK: begin
          if (c == "/") mode = M_BLK_SLASH;
          else if (c == "*") mode = M_BLK_STAR;
        end
        M_BLK_SLASH: begin
          if (c == "*") begin
            if (depth >= MAX_NESTING) raise_error(E_DEEP, tok_start, inc_sat(off));
            else begin
              depth++;
              mode = M_BLK;
            end
          end else begin
            mode = M_BLK;
            again = 1;
          end
        end
        M_BLK_STAR: begin
          if (c == "/") begin
            if (depth > 0) depth--;
            mode = (depth == 0) ? M_START : M_BLK;
          end else begin
            mode = M_BLK;
            again = 1;
          end
        end
        M_IDENT: begin
          if (m_alpha(c) || m_digit(c)) word_add(c);
          else begin
            word_end(off);
            again = 1;
          end
        end
        M_ZERO: begin
          if (c == "o" || c == "x" || c == "b") begin
            radix = (c == "o") ? 8 : (c == "x") ? 16 : 2;
            mode = M_PREFIX;
          end else begin
            mode = M_DEC_D;
            again = 1;
          end
        end
        M_DEC_D, M_DEC_U: begin
          if (m_digit(c)) mode = M_DEC_D;
          else if (c == "_" && mode == M_DEC_D) mode = M_DEC_U;
          else begin
            add_token(K_INT, tok_start, off, E_NONE);
            mode = M_START;
            again = 1;
          end
        end
        M_PREFIX: begin
          if (m_radix_digit(c)) mode = M_BASE_D;
          else begin
            add_token(K_INT, tok_start, inc_sat(tok_start), E_NONE);
            word_begin((radix == 8) ? "o" : (radix == 16) ? "x" : "b", inc_sat(tok_start));
            again = 1;
          end
        end
        M_BASE_D, M_BASE_U: begin
          if (m_radix_digit(c)) mode = M_BASE_D;
          else if (c == "_" && mode == M_BASE_D) mode = M_BASE_U;
          else begin
            add_token(K_INT, tok_start, off, E_NONE);
            mode = M_START;
            again = 1;
          end
        end
        M_ASM_WS: begin
          if (c == "{") mode = M_ASM_BODY;
          else if (!m_space(c)) raise_error(E_NO_BRACE, off, inc_sat(off));
        end
        M_ASM_BODY: begin
          if (c == "}") begin
            add_token(K_ASM, tok_start, inc_sat(off), E_NONE);
            mode = M_START;
          end else if (c == "/") mode = M_ASM_SLASH;
        end
        M_ASM_SLASH: begin
          if (c == "/") mode = M_ASM_LINE;
          else begin
            mode = M_ASM_BODY;
            again = 1;
          end
        end
        M_ASM_LINE: if (c == 8'h0A) mode = M_ASM_BODY;
        default: ;
      endcase
    end
  endtask

  // Closes the source: pending token, open constructs, and the end-of-file token unless discarding.
  task automatic lex_end(input logic [31:0] len);
    if (mode == M_IDENT) word_end(len);
    case (mode)
      M_MINUS: add_token(K_MINUS, tok_start, inc_sat(tok_start), E_NONE);
      M_SLASH: add_token(K_SLASH, tok_start, inc_sat(tok_start), E_NONE);
      M_ZERO, M_DEC_D, M_DEC_U, M_BASE_D, M_BASE_U:
        add_token(K_INT, tok_start, len, E_NONE);
      M_PREFIX: begin
        add_token(K_INT, tok_start, inc_sat(tok_start), E_NONE);
        add_token(K_IDENT, inc_sat(tok_start), len, E_NONE);
      end
      M_BLK, M_BLK_SLASH, M_BLK_STAR: raise_error(E_UNCLOSED, tok_start, len);
      M_ASM_WS: raise_error(E_EOF_BSM, tok_start, len);
      M_ASM_BODY, M_ASM_SLASH, M_ASM_LINE: raise_error(E_ASM_OPEN, tok_start, len);
      default: ;
    endcase
    if (mode != M_DISCARD) add_token(K_EOF, len, inc_sat(len), E_NONE);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: token %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Predict on each accepted byte, compare each accepted token.
  always @(posedge clk) begin
    out_item_t want;
    logic [31:0] off;
    if (!rst_n) begin
      lexer_reset();
      token_queue.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        step_tokens.delete();
        off = cur_off;
        lex_byte(in_data.source_byte, off);
        if (in_data.final_byte) begin
          lex_end(inc_sat(off));
          lexer_reset();
        end else begin
          cur_off = inc_sat(off);
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].run_end = 1'b1;
        token_queue = {token_queue, step_tokens};
      end
      if (out_valid && !out_stall) begin
        if (token_queue.size() == 0) begin
          report("unexpected", 32'(out_data.token_kind), 32'd0);
        end else begin
          want = token_queue.pop_front();
          if (out_data.token_kind != want.token_kind)
            report("kind", 32'(out_data.token_kind), 32'(want.token_kind));
          if (out_data.start_offset != want.start_offset)
            report("start", out_data.start_offset, want.start_offset);
          if (out_data.end_offset != want.end_offset)
            report("end", out_data.end_offset, want.end_offset);
          if (out_data.error_code != want.error_code)
            report("error", 32'(out_data.error_code), 32'(want.error_code));
          if (out_data.run_end != want.run_end)
            report("run_end", 32'(out_data.run_end), 32'(want.run_end));
        end
      end
    end
  end

endmodule

// ===== dv/source_tokenizer_test.sv =====
// Top of the source tokenizer test: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module source_tokenizer_test;
  import stok_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        pending_tokens;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_cycles;

  source_tokenizer u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  source_tokenizer_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_tokens(pending_tokens)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver stall: random idling, or a long hold-off while hold_cycles runs down.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offers one byte and waits until it is accepted; valid stays up for the next byte.
  task automatic send_byte(input logic [7:0] c, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{source_byte: c, final_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], last && i == s.len() - 1);
  endtask

  // Picks one piece of well-formed or broken source text.
  function automatic string pick_fragment();
    string ops[14];
    string hex;
    ops = '{"+", "->", "-", "*", "/", "%", "(", ")", ";", "{", "}", ":", ",", "="};
    case ($urandom_range(15))
      0, 1: return ops[$urandom_range(13)];
      2: return $sformatf("%s ", KwDump);
      3: return "function ";
      4: return "let ";
      5: return $sformatf("v%0d_x ", $urandom_range(999));
      6: return $sformatf("%0d_%0d ", $urandom_range(99), $urandom_range(99));
      7: begin
        hex = "0x";
        hex = {hex, $sformatf("%0h_%0h", $urandom_range(255), $urandom_range(15))};
        return hex;
      end
      8: begin
        if ($urandom_range(1) != 0) return "0b10_1";
        return "0o7_5 ";
      end
      9: begin
        if ($urandom_range(1) != 0) return "0xg ";
        return "0b";
      end
      10: return "// note\n";
      11: return "/* a /* b */ c */";
      12: return "bsm { mov // }\n x }";
      13: begin
        if ($urandom_range(1) != 0) return " \t\n";
        return "bsm x";
      end
      14: return "abcdefghijklmnopqrstuvwxyz_0123456789 ";
      default: begin
        if ($urandom_range(1) != 0) return "#";
        return "/* open";
      end
    endcase
  endfunction

  task automatic random_phase(input int count);
    int sent;
    string frag;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(19) == 0) begin
        // Raw noise byte, sometimes ending the source.
        send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        sent++;
      end else begin
        frag = pick_fragment();
        for (int i = 0; i < frag.len(); i++) send_byte(frag[i], 1'b0);
        sent += frag.len();
        if ($urandom_range(4) == 0) begin
          send_byte(" ", 1'b1);
          sent++;
        end
      end
    end
    send_byte(";", 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed sources: operators, keywords, literals, comments, assembly, errors.
    send_text("+->-*/%():;{},=a", 1'b1);
    send_text($sformatf("let function %s bsm{x}0x1f 0b 0o7_", KwDump), 1'b1);
    send_text("/*/**/*/0x", 1'b1);
    send_text("bsm", 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte("-", 1'b1);

    // Long hold-off at the receiver while bytes keep coming.
    hold_cycles = 40;
    send_text("+*%();:,=", 1'b1);

    send_idle_pct = 28;
    recv_idle_pct = 77;
    random_phase(100);
    send_idle_pct = 77;
    recv_idle_pct = 28;
    random_phase(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(110);
    in_valid <= 1'b0;

    while (pending_tokens != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
